[src/svp_pkg.sv]
// shared types and constants for the sprite view projection block
// no dependencies
`default_nettype none
package svp_pkg;
	localparam int MaxSpritesDefault = 128;
	localparam logic [31:0] NearLimit = 32'd4194304;
	localparam logic [17:0] SevenThirds = 18'd152917;
	localparam logic [31:0] AllOnes = 32'hffffffff;

	typedef enum logic [1:0] {OP_FRAME = 2'd0, OP_THING = 2'd1, OP_WEAPON = 2'd2, OP_NONE = 2'd3} op_t;
	typedef enum logic [2:0] {
		ST_STORED = 3'd0, ST_NEAR = 3'd1, ST_SIDE = 3'd2, ST_FULL = 3'd3, ST_FRAME = 3'd4
	} status_t;
	typedef enum logic [1:0] {
		REG_POS_X = 2'd0, REG_POS_Y = 2'd1, REG_COS = 2'd2, REG_SIN = 2'd3
	} reg_idx_t;
	typedef enum logic [3:0] {
		BK_IDLE, BK_MUL1, BK_MUL2, BK_CHECK, BK_DIVX, BK_MULY, BK_DIVXS, BK_DIVYS, BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic signed [31:0] pos_a;
		logic signed [31:0] pos_b;
		logic [13:0] lump_base;
		logic [15:0] frame_word;
		logic [7:0] light_level;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] slot;
		logic [16:0] graphic_index;
		logic signed [31:0] screen_left;
		logic [16:0] x_scale;
		logic [17:0] y_scale;
		logic [31:0] x_step;
		logic [31:0] y_step;
		logic signed [31:0] texture_mid;
		logic [7:0] shade_index;
	} out_item_t;

	// classified request handed from front to back
	typedef struct packed {
		op_t op;
		logic signed [31:0] trx;
		logic signed [31:0] try_v;
		logic signed [31:0] pos_a;
		logic signed [31:0] pos_b;
		logic [16:0] gfx;
		logic [7:0] shade;
	} job_t;
endpackage
`default_nettype wire

[src/svp_div.sv]
// restoring divider, one quotient bit per cycle
// uses svp_pkg
`default_nettype none
module svp_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [47:0] dividend,
	input wire logic [31:0] divisor,
	output logic busy,
	output logic [47:0] quotient
);
	import svp_pkg::*;
	logic [47:0] q_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic [5:0] cnt_q;
	logic [32:0] r_sh;
	logic [32:0] r_sub;

	// shift in one dividend bit and trial subtract
	always_comb begin
		r_sh = {r_q[31:0], q_q[47]};
		r_sub = r_sh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd48;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != 6'd0) begin
			if (!r_sub[32]) begin
				r_q <= r_sub;
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 6'd0);
	assign quotient = q_q;
endmodule
`default_nettype wire

[src/svp_front.sv]
// front: accepts requests, drops unused codes, translates by viewer position
// uses svp_pkg
`default_nettype none
module svp_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input svp_pkg::in_item_t in_data,
	output logic in_stall,
	input wire logic signed [31:0] view_x,
	input wire logic signed [31:0] view_y,
	output logic job_valid,
	output svp_pkg::job_t job,
	input wire logic job_stall
);
	import svp_pkg::*;
	logic v_q;
	job_t job_q;
	logic take;

	assign in_stall = v_q && job_stall;
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (take) begin
			v_q <= (op_t'(in_data.opcode) != OP_NONE);
		end else if (!job_stall) begin
			v_q <= 1'b0;
		end
	end

	// classify and precompute the cheap fields
	always_ff @(posedge clk) begin
		if (take) begin
			job_q.op <= op_t'(in_data.opcode);
			job_q.trx <= in_data.pos_a - view_x;
			job_q.try_v <= in_data.pos_b - view_y;
			job_q.pos_a <= in_data.pos_a;
			job_q.pos_b <= in_data.pos_b;
			job_q.gfx <= {3'b0, in_data.lump_base} + {1'b0, in_data.frame_word[14:0], 1'b0};
			job_q.shade <= in_data.frame_word[15] ? 8'd255 : in_data.light_level;
		end
	end

	assign job_valid = v_q;
	assign job = job_q;
endmodule
`default_nettype wire

[src/svp_fifo.sv]
// two-entry request queue between front and back
// uses svp_pkg
`default_nettype none
module svp_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	input svp_pkg::job_t wr_data,
	output logic wr_stall,
	output logic rd_valid,
	output svp_pkg::job_t rd_data,
	input wire logic rd_take
);
	import svp_pkg::*;
	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_stall = (cnt_q == 2'd2);
	assign wr = wr_valid && !wr_stall;
	assign rd_valid = (cnt_q != 2'd0);
	assign rd = rd_take && rd_valid;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

[src/svp_back.sv]
// back: rotation, culling, slot allocation, scales and reciprocals
// uses svp_pkg and svp_div
`default_nettype none
module svp_back #(
	parameter int MAX_SPRITES = svp_pkg::MaxSpritesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	input svp_pkg::job_t job,
	output logic job_take,
	input wire logic signed [17:0] view_cos,
	input wire logic signed [17:0] view_sin,
	output logic out_valid,
	output svp_pkg::out_item_t out_data,
	input wire logic out_stall
);
	import svp_pkg::*;
	// counter is at least as wide as the slot field
	localparam int SW = ($clog2(MAX_SPRITES + 1) > 7) ? $clog2(MAX_SPRITES + 1) : 7;

	bk_state_t st_q, st_d;
	job_t j_q;
	logic [SW-1:0] used_q;
	logic signed [31:0] tz_q, tx_q, gc_q, gs_q;
	logic [16:0] xs_q;
	logic [17:0] ys_q;
	logic [31:0] xst_q;
	out_item_t res_q;
	out_item_t res_init;
	logic ov_q;

	logic signed [49:0] p_c, p_s;
	logic signed [31:0] gc, gs;
	logic signed [34:0] bound;
	logic signed [34:0] tx_ext;
	logic [34:0] ys_full;
	logic div_start, div_busy;
	logic [47:0] div_dnd, div_q;
	logic [31:0] div_dsr;
	logic full;

	svp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dnd),
		.divisor(div_dsr), .busy(div_busy), .quotient(div_q)
	);

	assign full = ({{(32-SW){1'b0}}, used_q} >= 32'(MAX_SPRITES));

	// one pair of 32x18 products per cycle; floor shift is an arithmetic shift
	always_comb begin
		if (st_q == BK_MUL1) begin
			p_c = j_q.trx * view_cos;
			p_s = j_q.try_v * view_sin;
		end else begin
			p_c = j_q.try_v * view_cos;
			p_s = j_q.trx * view_sin;
		end
		gc = p_c[47:16];
		gs = p_s[47:16];
		bound = {tz_q[31], tz_q[31], tz_q, 1'b0} <<< 1;
		tx_ext = {{3{tx_q[31]}}, tx_q};
		ys_full = ({18'b0, xs_q} * {17'b0, SevenThirds}) >> 16;
	end

	// result of a request that needs no projection
	always_comb begin
		res_init = '0;
		unique case (job.op)
			OP_FRAME: res_init.status = ST_FRAME;
			OP_WEAPON: begin
				if (full) res_init.status = ST_FULL;
				else begin
					res_init.status = ST_STORED;
					res_init.slot = used_q[6:0];
					res_init.graphic_index = job.gfx;
					res_init.screen_left = job.pos_a >>> 16;
					res_init.texture_mid = job.pos_b;
					res_init.shade_index = job.shade;
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (job_valid) begin
				unique case (job.op)
					OP_THING: st_d = BK_MUL1;
					default: st_d = BK_DONE;
				endcase
			end
			BK_MUL1: st_d = BK_MUL2;
			BK_MUL2: st_d = BK_CHECK;
			BK_CHECK: st_d = BK_DIVX;
			BK_DIVX: if (!div_busy) st_d = BK_MULY;
			BK_MULY: st_d = BK_DIVXS;
			BK_DIVXS: if (!div_busy) st_d = BK_DIVYS;
			BK_DIVYS: if (!div_busy) st_d = BK_DONE;
			BK_DONE: if (!ov_q || !out_stall) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
		if (st_q == BK_CHECK && (tz_q < $signed(NearLimit)
			|| tx_ext > bound || tx_ext < -bound || full))
			st_d = BK_DONE;
	end

	// outputs of the sequencer
	always_comb begin
		job_take = (st_q == BK_IDLE) && job_valid;
		div_start = 1'b0;
		div_dnd = '0;
		div_dsr = '0;
		unique case (st_q)
			BK_CHECK: begin
				div_start = 1'b1;
				div_dnd = {NearLimit[31:0], 16'b0};
				div_dsr = tz_q;
			end
			BK_MULY: begin
				div_start = 1'b1;
				div_dnd = {16'b0, AllOnes};
				div_dsr = {15'b0, xs_q};
			end
			BK_DIVXS: if (!div_busy) begin
				div_start = 1'b1;
				div_dnd = {16'b0, AllOnes};
				div_dsr = {14'b0, ys_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			used_q <= '0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			if (st_q == BK_DONE && (!ov_q || !out_stall)) ov_q <= 1'b1;
			if (st_q == BK_IDLE && job_valid) begin
				if (job.op == OP_FRAME) used_q <= '0;
				else if (job.op == OP_WEAPON && !full) used_q <= used_q + 1'b1;
			end
			if (st_q == BK_CHECK && st_d != BK_DONE) used_q <= used_q + 1'b1;
		end
	end

	// datapath and result assembly
	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE && job_valid) begin
			j_q <= job;
			res_q <= res_init;
		end
		if (st_q == BK_MUL1) begin
			gc_q <= gc;
			gs_q <= gs;
		end
		if (st_q == BK_MUL2) begin
			tz_q <= gc_q + gs_q;
			tx_q <= gs - gc;
		end
		if (st_q == BK_CHECK) begin
			if (tz_q < $signed(NearLimit)) res_q.status <= ST_NEAR;
			else if (tx_ext > bound || tx_ext < -bound) res_q.status <= ST_SIDE;
			else if (full) res_q.status <= ST_FULL;
			else begin
				res_q.status <= ST_STORED;
				res_q.slot <= used_q[6:0];
				res_q.graphic_index <= j_q.gfx;
				res_q.screen_left <= tx_q;
				res_q.shade_index <= j_q.shade;
			end
		end
		if (st_q == BK_DIVX && !div_busy) xs_q <= div_q[16:0];
		if (st_q == BK_MULY) begin
			ys_q <= ys_full[17:0];
			res_q.x_scale <= xs_q;
			res_q.y_scale <= ys_full[17:0];
		end
		if (st_q == BK_DIVXS && !div_busy) xst_q <= div_q[31:0];
		if (st_q == BK_DIVYS && !div_busy) begin
			res_q.x_step <= (xs_q == '0) ? 32'd0 : xst_q;
			res_q.y_step <= (ys_q == '0) ? 32'd0 : div_q[31:0];
		end
		if (st_q == BK_DONE && (!ov_q || !out_stall)) out_data <= res_q;
	end

	assign out_valid = ov_q;
endmodule
`default_nettype wire

[src/sprite_view_projection_unit.sv]
// Sprite view projection: one result per request (unused opcode 3 gives none). A frame
// start or weapon sprite needs no projection; the time for a world thing is set by the
// three passes of the single shared bit-serial divider (scale and two steps).
// A front stage and a two-entry queue keep accepting while the back end works, until they fill.
// uses svp_pkg, svp_front, svp_fifo, svp_back
`default_nettype none
module sprite_view_projection_unit #(
	parameter int MAX_SPRITES = svp_pkg::MaxSpritesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input svp_pkg::in_item_t in_data,
	output logic in_stall,
	output logic out_valid,
	output svp_pkg::out_item_t out_data,
	input wire logic out_stall,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	import svp_pkg::*;
	logic signed [31:0] vx_q, vy_q;
	logic signed [17:0] vc_q, vs_q;
	logic fj_valid, fj_stall, qj_valid, qj_take;
	job_t fj, qj;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_q <= '0;
			vy_q <= '0;
			vc_q <= 18'sd65536;
			vs_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_POS_X: vx_q <= cfg_data;
				REG_POS_Y: vy_q <= cfg_data;
				REG_COS: vc_q <= cfg_data[17:0];
				REG_SIN: vs_q <= cfg_data[17:0];
			endcase
		end
	end

	svp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_data(in_data),
		.in_stall(in_stall), .view_x(vx_q), .view_y(vy_q),
		.job_valid(fj_valid), .job(fj), .job_stall(fj_stall)
	);

	svp_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(fj_valid), .wr_data(fj),
		.wr_stall(fj_stall), .rd_valid(qj_valid), .rd_data(qj), .rd_take(qj_take)
	);

	svp_back #(.MAX_SPRITES(MAX_SPRITES)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(qj_valid), .job(qj), .job_take(qj_take),
		.view_cos(vc_q), .view_sin(vs_q), .out_valid(out_valid), .out_data(out_data),
		.out_stall(out_stall)
	);
endmodule
`default_nettype wire

[sim/svp_checker.sv]
// checker for the sprite view projection block: watches the three channels,
// predicts each result in 16.16 fixed point and compares it field by field
// depends on svp_pkg
`default_nettype none
module svp_checker #(
	parameter int MAX_SPRITES = svp_pkg::MaxSpritesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input svp_pkg::in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_stall,
	input svp_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data,
	output int fail_count,
	output int pending,
	output int stored_cnt,
	output int culled_cnt,
	output int full_cnt,
	output int frame_cnt
);
	import svp_pkg::*;

	out_item_t expected_sprites[$];
	logic signed [31:0] view_x;
	logic signed [31:0] view_y;
	logic signed [17:0] view_cos;
	logic signed [17:0] view_sin;
	int slots_used;

	// 16.16 multiply: exact product, floor shift, wrap to 32 bits
	function automatic logic signed [31:0] fx_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		return 32'(p >>> 16);
	endfunction

	// work out the result of one request and queue it
	task automatic project_request(input in_item_t req);
		out_item_t r;
		logic signed [31:0] trx, try_v, gx, gy, tz, tx;
		longint bound, xs, ys;
		logic [16:0] gfx;
		logic [7:0] shade;
		if (op_t'(req.opcode) == OP_NONE)
			return;
		r = '0;
		gfx = 17'(req.lump_base) + {1'b0, req.frame_word[14:0], 1'b0};
		shade = req.frame_word[15] ? 8'd255 : req.light_level;
		case (op_t'(req.opcode))
			OP_FRAME: begin
				slots_used = 0;
				r.status = ST_FRAME;
			end
			OP_WEAPON: begin
				if (slots_used >= MAX_SPRITES) begin
					r.status = ST_FULL;
				end else begin
					r.status = ST_STORED;
					r.slot = 7'(slots_used);
					slots_used++;
					r.graphic_index = gfx;
					r.screen_left = req.pos_a >>> 16;
					r.texture_mid = req.pos_b;
					r.shade_index = shade;
				end
			end
			default: begin
				trx = req.pos_a - view_x;
				try_v = req.pos_b - view_y;
				gx = fx_mul(trx, view_cos);
				gy = -fx_mul(try_v, view_sin);
				tz = gx - gy;
				if (tz < $signed(NearLimit)) begin
					r.status = ST_NEAR;
				end else begin
					gx = -fx_mul(trx, view_sin);
					gy = fx_mul(try_v, view_cos);
					tx = -(gy + gx);
					bound = longint'(tz) * 4;
					if (longint'(tx) > bound || longint'(tx) < -bound) begin
						r.status = ST_SIDE;
					end else if (slots_used >= MAX_SPRITES) begin
						r.status = ST_FULL;
					end else begin
						r.status = ST_STORED;
						r.slot = 7'(slots_used);
						slots_used++;
						xs = (longint'(1) << 38) / longint'(tz);
						ys = longint'(fx_mul(xs, longint'(SevenThirds)));
						r.graphic_index = gfx;
						r.screen_left = tx;
						r.x_scale = 17'(xs);
						r.y_scale = 18'(ys);
						r.x_step = (xs > 0) ? 32'(longint'(AllOnes) / xs) : '0;
						r.y_step = (ys > 0) ? 32'(longint'(AllOnes) / ys) : '0;
						r.shade_index = shade;
					end
				end
			end
		endcase
		expected_sprites.push_back(r);
	endtask

	task automatic cmp_field(input string name, input longint e, input longint a);
		if (e != a) begin
			$display("%0t: mismatch in %s: expected %0d (0x%0h), actual %0d (0x%0h)",
				$time, name, e, e, a, a);
			fail_count++;
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t e;
		e = expected_sprites.pop_front();
		cmp_field("status", e.status, got.status);
		cmp_field("slot", e.slot, got.slot);
		cmp_field("graphic_index", e.graphic_index, got.graphic_index);
		cmp_field("screen_left", e.screen_left, got.screen_left);
		cmp_field("x_scale", e.x_scale, got.x_scale);
		cmp_field("y_scale", e.y_scale, got.y_scale);
		cmp_field("x_step", e.x_step, got.x_step);
		cmp_field("y_step", e.y_step, got.y_step);
		cmp_field("texture_mid", e.texture_mid, got.texture_mid);
		cmp_field("shade_index", e.shade_index, got.shade_index);
		case (status_t'(e.status))
			ST_STORED: stored_cnt++;
			ST_FULL: full_cnt++;
			ST_FRAME: frame_cnt++;
			default: culled_cnt++;
		endcase
	endtask

	// follow the channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x <= '0;
			view_y <= '0;
			view_cos <= 18'sd65536;
			view_sin <= '0;
			slots_used = 0;
			expected_sprites.delete();
			fail_count <= 0;
			pending <= 0;
			stored_cnt <= 0;
			culled_cnt <= 0;
			full_cnt <= 0;
			frame_cnt <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_POS_X: view_x <= cfg_data;
					REG_POS_Y: view_y <= cfg_data;
					REG_COS: view_cos <= cfg_data[17:0];
					default: view_sin <= cfg_data[17:0];
				endcase
			end
			if (in_valid && !in_stall)
				project_request(in_data);
			if (out_valid && !out_stall) begin
				if (expected_sprites.size() == 0) begin
					$display("%0t: result with none expected, actual status %0d slot %0d",
						$time, out_data.status, out_data.slot);
					fail_count++;
				end else begin
					check_result(out_data);
				end
			end
			pending <= expected_sprites.size();
		end
	end
endmodule
`default_nettype wire

[sim/tb_sprite_view_projection_unit.sv]
// testbench top for the sprite view projection block: drives directed and
// random sprite requests and view settings, stalls the output, gives the verdict
// depends on svp_pkg, svp_checker and the block itself
`default_nettype none
module tb_sprite_view_projection_unit;
	import svp_pkg::*;

	localparam int MaxSprites = 128;
	localparam int IdleLimit = 5000;
	localparam int SettleCycles = 200;

	logic clk;
	logic arst_n;
	logic in_valid;
	in_item_t in_data;
	logic in_stall;
	logic out_valid;
	out_item_t out_data;
	logic out_stall = 1'b0;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	int fail_count, pending, stored_cnt, culled_cnt, full_cnt, frame_cnt;
	int idle_cycles = 0;
	int sent_cnt;
	bit quiet;
	int stall_left = 0;
	bit stall_mode;

	// copy of the view as last written
	logic signed [31:0] cur_x, cur_y;
	logic signed [17:0] cur_cos, cur_sin;

	sprite_view_projection_unit #(.MAX_SPRITES(MaxSprites)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
		.out_valid(out_valid), .out_data(out_data), .out_stall(out_stall),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	svp_checker #(.MAX_SPRITES(MaxSprites)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .stored_cnt(stored_cnt),
		.culled_cnt(culled_cnt), .full_cnt(full_cnt), .frame_cnt(frame_cnt)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// output stall in random bursts, none in the quiet tail
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_mode = ($urandom_range(0, 9) < 4);
			stall_left <= stall_mode ? $urandom_range(1, 12) : $urandom_range(1, 40);
			out_stall <= stall_mode;
		end
	end

	// watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("timeout at %0t with %0d results outstanding", $time, pending);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_view(input logic [31:0] x, input logic [31:0] y,
			input logic [17:0] c, input logic [17:0] s);
		write_reg(REG_POS_X, x);
		write_reg(REG_POS_Y, y);
		write_reg(REG_COS, {{14{c[17]}}, c});
		write_reg(REG_SIN, {{14{s[17]}}, s});
		cfg_valid <= 1'b0;
		cur_x = x;
		cur_y = y;
		cur_cos = c;
		cur_sin = s;
	endtask

	// drain all results, then wait long enough for the pipe to empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic send_req(input in_item_t req);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		if (op_t'(req.opcode) != OP_NONE)
			sent_cnt++;
	endtask

	function automatic in_item_t rand_req(input op_t op);
		in_item_t r;
		r.opcode = op;
		r.pos_a = $urandom;
		r.pos_b = $urandom;
		r.lump_base = 14'($urandom);
		r.frame_word = 16'($urandom);
		r.light_level = 8'($urandom);
		return r;
	endfunction

	// place a thing at a chosen view depth and side offset
	function automatic in_item_t thing_at(input longint depth, input longint side);
		in_item_t r;
		longint trx, try_v;
		r = rand_req(OP_THING);
		trx = (depth * cur_cos + side * cur_sin) >>> 16;
		try_v = (depth * cur_sin - side * cur_cos) >>> 16;
		r.pos_a = cur_x + 32'(trx);
		r.pos_b = cur_y + 32'(try_v);
		return r;
	endfunction

	function automatic in_item_t direct(input op_t op, input logic [31:0] a,
			input logic [31:0] b);
		in_item_t r;
		r = rand_req(op);
		r.pos_a = a;
		r.pos_b = b;
		return r;
	endfunction

	// one phase of random requests; frame_pct_x10 sets how often a frame starts, in tenths of a percent
	task automatic random_phase(input int count, input int frame_pct_x10);
		in_item_t r;
		int k, pick;
		longint depth, side;
		k = 0;
		while (k < count) begin
			if (sent_cnt > 1280)
				quiet = 1'b1;
			pick = $urandom_range(0, 999);
			if (pick < 15) begin
				send_req(rand_req(OP_NONE));
				continue;
			end
			pick = $urandom_range(0, 999);
			if (pick < frame_pct_x10) begin
				r = rand_req(OP_FRAME);
			end else if (pick < 250) begin
				r = rand_req(OP_WEAPON);
			end else if (pick < 350) begin
				r = rand_req(OP_THING);
			end else begin
				depth = $urandom_range(0, 9) == 0 ? $urandom_range(0, 32'h7fffffff)
					: $urandom_range(32'd3932160, 32'h10000000);
				side = (depth * 4 * (longint'($urandom_range(0, 131072)) - 65536)) >>> 16;
				if ($urandom_range(0, 6) == 0)
					side = side + side / 4;
				r = thing_at(depth, side);
			end
			send_req(r);
			k++;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_POS_X;
		cfg_data <= '0;
		sent_cnt = 0;
		quiet = 1'b0;
		cur_x = '0;
		cur_y = '0;
		cur_cos = 18'sd65536;
		cur_sin = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset view, so depth is pos_a and side is minus pos_b
		send_req(direct(OP_FRAME, '0, '0));
		send_req('{OP_WEAPON, 32'h80000000, 32'h7fffffff, 14'h3fff, 16'h7fff, 8'h00});
		send_req('{OP_WEAPON, 32'h7fffffff, 32'h80000000, 14'h0000, 16'hffff, 8'hff});
		send_req('{OP_WEAPON, 32'h00000000, 32'h00000000, 14'h1555, 16'h8000, 8'h5a});
		send_req(direct(OP_THING, 32'h003fffff, '0));
		send_req(direct(OP_THING, 32'h00400000, '0));
		send_req(direct(OP_THING, 32'h80000000, '0));
		send_req(direct(OP_THING, 32'h7fffffff, '0));
		send_req(direct(OP_THING, 32'h7fffffff, 32'h80000000));
		send_req(direct(OP_THING, 32'h00400000, -32'sh01000000));
		send_req(direct(OP_THING, 32'h00400000, -32'sh01000001));
		send_req(direct(OP_THING, 32'h00400000, 32'h01000000));
		send_req(direct(OP_THING, 32'h00400000, 32'h01000001));
		send_req(direct(OP_THING, 32'hffffffff, 32'h7fffffff));
		send_req(direct(OP_NONE, 32'h00800000, '0));
		send_req(direct(OP_FRAME, '0, '0));
		send_req(direct(OP_THING, 32'h00800000, '0));
		send_req(direct(OP_WEAPON, 32'h0000ffff, 32'hffff0000));
		random_phase(150, 20);

		// view settings in turn, extremes among them
		settle();
		set_view(32'h0, 32'h0, 18'sd0, 18'sd65536);
		random_phase(200, 20);
		settle();
		set_view(32'h7fffffff, 32'h80000000, -18'sd65536, 18'sd0);
		random_phase(200, 3);
		settle();
		set_view(32'h80000000, 32'h7fffffff, 18'sd46341, -18'sd46341);
		random_phase(200, 10);
		settle();
		set_view($urandom, $urandom, 18'sd0, -18'sd65536);
		random_phase(200, 20);
		settle();
		set_view($urandom, $urandom, -18'sd65536, -18'sd65536);
		random_phase(150, 20);
		settle();
		set_view($urandom, $urandom, 18'($urandom_range(0, 131072) - 65536),
			18'($urandom_range(0, 131072) - 65536));
		random_phase(150, 20);
		settle();
		set_view($urandom, $urandom, 18'sd65536, 18'sd65536);
		random_phase(150, 20);

		settle();
		$display("covered %0d requests over eight view settings: %0d stored, %0d culled,",
			sent_cnt, stored_cnt, culled_cnt);
		$display("%0d with the buffer full, %0d frame starts", full_cnt, frame_cnt);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

[sprite_view_projection_unit.f]
src/svp_pkg.sv
src/svp_div.sv
src/svp_front.sv
src/svp_fifo.sv
src/svp_back.sv
src/sprite_view_projection_unit.sv
sim/svp_checker.sv
sim/tb_sprite_view_projection_unit.sv
